/* design/lavm_pkg.sv */
// ----------------------------------------------------------------------------
// lavm_pkg
// Shared types and constants for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lavm_pkg;

  // Unit axis component: signed Q2.16
  localparam int AXIS_W     = 18;
  localparam int FRAC_W     = 16;
  // Normalized magnitude width: the largest component sits in [2^29, 2^30)
  localparam int MAG_W      = 30;
  localparam int NORM_MSB   = 29;
  // Square root: one result bit per stage over a 64-bit radicand
  localparam int SUM_W      = 64;
  localparam int SQRT_STEPS = 32;
  // Quotient bits of the per-component divide (result never above 65536)
  localparam int QUO_W      = 17;
  // Register stages through one normalize unit
  localparam int NORM_LAT   = 57;

  typedef struct packed {
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
  } axis_t;

endpackage

/* design/lavm_norm.sv */
// ----------------------------------------------------------------------------
// lavm_norm
// Pipelined 3-vector normalize to Q2.16: magnitude scaling, 32-stage square
// root and 17-stage restoring divide per component. A zero vector gives zero.
// ----------------------------------------------------------------------------
module lavm_norm #(
  parameter int IN_W = 33
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [IN_W-1:0] vec_x,
  input  logic signed [IN_W-1:0] vec_y,
  input  logic signed [IN_W-1:0] vec_z,
  output lavm_pkg::axis_t        axis
);

  localparam int MW  = lavm_pkg::MAG_W;
  localparam int NG  = (IN_W + 7) / 8;
  localparam int GBW = NG * 8;
  localparam int PW  = $clog2(GBW);
  localparam int EW  = IN_W + MW;
  localparam int SQW = 2 * MW;
  localparam int SMW = lavm_pkg::SUM_W;
  localparam int NS  = lavm_pkg::SQRT_STEPS;
  localparam int ND  = lavm_pkg::QUO_W;
  localparam int FW  = lavm_pkg::FRAC_W;
  localparam int AW  = lavm_pkg::AXIS_W;
  localparam int RW  = MW + FW + 2;

  logic signed [IN_W-1:0] vin [3];
  assign vin[0] = vec_x;
  assign vin[1] = vec_y;
  assign vin[2] = vec_z;

  // Stage 1: magnitudes and signs
  logic [IN_W-1:0] a1 [3];
  logic [2:0]      sg1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sg1[i] <= vin[i][IN_W-1];
        a1[i]  <= vin[i][IN_W-1] ? (~vin[i] + 1'b1) : vin[i];
      end
    end
  end

  // Stage 2: leading-one search per byte of the OR of magnitudes
  logic [GBW-1:0] orw;
  logic [NG-1:0]  hit_c;
  logic [2:0]     lpos_c [NG];
  logic [IN_W-1:0] a2 [3];
  logic [2:0]      sg2;
  logic [NG-1:0]   hit2;
  logic [2:0]      lpos2 [NG];

  always_comb begin
    orw = GBW'(a1[0] | a1[1] | a1[2]);
    for (int g = 0; g < NG; g++) begin
      hit_c[g]  = |orw[g*8 +: 8];
      lpos_c[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (orw[g*8 + b]) lpos_c[g] = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2    <= a1;
      sg2   <= sg1;
      hit2  <= hit_c;
      lpos2 <= lpos_c;
    end
  end

  // Stage 3: pick the highest hit byte
  logic [PW-1:0]   p_c;
  logic [IN_W-1:0] a3 [3];
  logic [2:0]      sg3;
  logic [PW-1:0]   p3;
  logic            z3;

  always_comb begin
    p_c = '0;
    for (int g = 0; g < NG; g++) begin
      if (hit2[g]) p_c = PW'(g * 8) + PW'(lpos2[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a3  <= a2;
      sg3 <= sg2;
      p3  <= p_c;
      z3  <= ~|hit2;
    end
  end

  // Stage 4: shift so the largest magnitude lands in [2^29, 2^30)
  logic [EW-1:0] ext;
  logic [MW-1:0] b_c [3];
  logic [MW-1:0] b4 [3];
  logic [2:0]    sg4;
  logic          z4;

  always_comb begin
    ext = '0;
    for (int i = 0; i < 3; i++) begin
      ext = EW'(a3[i]);
      if (p3 >= PW'(lavm_pkg::NORM_MSB)) begin
        ext = ext >> (p3 - PW'(lavm_pkg::NORM_MSB));
      end else begin
        ext = ext << (PW'(lavm_pkg::NORM_MSB) - p3);
      end
      b_c[i] = ext[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b4  <= b_c;
      sg4 <= sg3;
      z4  <= z3;
    end
  end

  // Stage 5: squares
  logic [SQW-1:0] sq5 [3];
  logic [MW-1:0]  b5 [3];
  logic [2:0]     sg5;
  logic           z5;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq5[i] <= b4[i] * b4[i];
      end
      b5  <= b4;
      sg5 <= sg4;
      z5  <= z4;
    end
  end

  // Stage 6 (sqrt entry) and square root, one result bit per stage
  logic [SMW-1:0] sx [NS+1];
  logic [SMW-1:0] sr [NS+1];
  logic [MW-1:0]  sb [NS+1][3];
  logic [2:0]     ssg [NS+1];
  logic           sz [NS+1];
  logic [SMW-1:0] trial [NS];
  logic [SMW-1:0] sbit [NS];

  always_comb begin
    for (int j = 0; j < NS; j++) begin
      sbit[j]  = SMW'(1) << (2 * (NS - 1 - j));
      trial[j] = sr[j] + sbit[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx[0]  <= SMW'(sq5[0]) + SMW'(sq5[1]) + SMW'(sq5[2]);
      sr[0]  <= '0;
      sb[0]  <= b5;
      ssg[0] <= sg5;
      sz[0]  <= z5;
      for (int j = 0; j < NS; j++) begin
        if (sx[j] >= trial[j]) begin
          sx[j+1] <= sx[j] - trial[j];
          sr[j+1] <= (sr[j] >> 1) + sbit[j];
        end else begin
          sx[j+1] <= sx[j];
          sr[j+1] <= sr[j] >> 1;
        end
        sb[j+1]  <= sb[j];
        ssg[j+1] <= ssg[j];
        sz[j+1]  <= sz[j];
      end
    end
  end

  // Divide entry: numerator |c|*2^16 + s/2, then restoring divide by s
  logic [MW:0]    s_fin;
  logic [RW-1:0]  rem [ND+1][3];
  logic [ND-1:0]  qt [ND+1][3];
  logic [MW:0]    ds [ND+1];
  logic [2:0]     dg [ND+1];
  logic           dz [ND+1];
  logic [RW-1:0]  dvs [ND];

  assign s_fin = sr[NS][MW:0];

  always_comb begin
    for (int j = 0; j < ND; j++) begin
      dvs[j] = RW'(ds[j]) << (ND - 1 - j);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rem[0][i] <= RW'({sb[NS][i], {FW{1'b0}}}) + RW'(s_fin >> 1);
        qt[0][i]  <= '0;
      end
      ds[0] <= s_fin;
      dg[0] <= ssg[NS];
      dz[0] <= sz[NS];
      for (int j = 0; j < ND; j++) begin
        for (int i = 0; i < 3; i++) begin
          if (rem[j][i] >= dvs[j]) begin
            rem[j+1][i] <= rem[j][i] - dvs[j];
            qt[j+1][i]  <= qt[j][i] | (ND'(1) << (ND - 1 - j));
          end else begin
            rem[j+1][i] <= rem[j][i];
            qt[j+1][i]  <= qt[j][i];
          end
        end
        ds[j+1] <= ds[j];
        dg[j+1] <= dg[j];
        dz[j+1] <= dz[j];
      end
    end
  end

  // Final stage: restore sign, zero vector gives zero
  function automatic logic signed [AW-1:0] apply_sign(
    input logic [ND-1:0] q,
    input logic          neg,
    input logic          zero
  );
    logic signed [AW-1:0] mag;
    mag = signed'(AW'(q));
    if (zero) return '0;
    return neg ? -mag : mag;
  endfunction

  lavm_pkg::axis_t axis_r;

  always_ff @(posedge clk) begin
    if (en) begin
      axis_r.x <= apply_sign(qt[ND][0], dg[ND][0], dz[ND]);
      axis_r.y <= apply_sign(qt[ND][1], dg[ND][1], dz[ND]);
      axis_r.z <= apply_sign(qt[ND][2], dg[ND][2], dz[ND]);
    end
  end

  assign axis = axis_r;

endmodule

/* design/look_at_view_matrix_core.sv */
// ----------------------------------------------------------------------------
// look_at_view_matrix_core
// Left-handed look-at view matrix from eye, target and up (signed Q16.16):
// rotation columns right, up and look in Q2.16, translation as minus the dot
// of each axis with eye, rounded and saturated to Q16.16. A zero-length
// vector normalizes to zero. The block takes one beat per clock when the
// output is not stalled. Three normalize units lie in series, each with a
// 32-stage square root and a 17-stage divide. The last pipeline stage and
// the output register let a new beat enter while a result waits.
// ----------------------------------------------------------------------------
module look_at_view_matrix_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic signed [31:0] upward_x,
  input  logic signed [31:0] upward_y,
  input  logic signed [31:0] upward_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] m11,
  output logic signed [17:0] m12,
  output logic signed [17:0] m13,
  output logic signed [17:0] m21,
  output logic signed [17:0] m22,
  output logic signed [17:0] m23,
  output logic signed [17:0] m31,
  output logic signed [17:0] m32,
  output logic signed [17:0] m33,
  output logic signed [31:0] tx,
  output logic signed [31:0] ty,
  output logic signed [31:0] tz
);

  localparam int NL    = lavm_pkg::NORM_LAT;
  localparam int LA    = 1 + NL;
  localparam int LB    = LA + 2 + NL;
  localparam int LC    = LB + 2 + NL;
  localparam int DEPTH = LC + 3;
  localparam int XL    = 2 + NL;

  // Pipeline advance and valid tracking
  logic             en;
  logic [DEPTH-1:0] vld;

  assign en       = !vld[DEPTH-1] || !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // Entry: view direction
  logic signed [32:0] dx, dy, dz;

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= 33'(target_x) - 33'(eye_x);
      dy <= 33'(target_y) - 33'(eye_y);
      dz <= 33'(target_z) - 33'(eye_z);
    end
  end

  // Side delay lines for eye, up and earlier axes
  logic [95:0]     upl [LA];
  logic [95:0]     eyel [LC];
  lavm_pkg::axis_t look, right, upv;
  lavm_pkg::axis_t lookb [XL];
  lavm_pkg::axis_t lookc [XL];
  lavm_pkg::axis_t rightc [XL];

  always_ff @(posedge clk) begin
    if (en) begin
      upl[0]    <= {upward_x, upward_y, upward_z};
      eyel[0]   <= {eye_x, eye_y, eye_z};
      lookb[0]  <= look;
      lookc[0]  <= lookb[XL-1];
      rightc[0] <= right;
      for (int i = 1; i < LA; i++) upl[i] <= upl[i-1];
      for (int i = 1; i < LC; i++) eyel[i] <= eyel[i-1];
      for (int i = 1; i < XL; i++) begin
        lookb[i]  <= lookb[i-1];
        lookc[i]  <= lookc[i-1];
        rightc[i] <= rightc[i-1];
      end
    end
  end

  lavm_norm #(.IN_W(33)) u_norm_look (
    .clk  (clk),
    .en   (en),
    .vec_x(dx),
    .vec_y(dy),
    .vec_z(dz),
    .axis (look)
  );

  // Cross up x look
  logic signed [31:0] ux, uy, uz;
  logic signed [49:0] pr1 [6];
  logic signed [50:0] c1x, c1y, c1z;

  assign ux = $signed(upl[LA-1][95:64]);
  assign uy = $signed(upl[LA-1][63:32]);
  assign uz = $signed(upl[LA-1][31:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      pr1[0] <= uy * look.z;
      pr1[1] <= uz * look.y;
      pr1[2] <= uz * look.x;
      pr1[3] <= ux * look.z;
      pr1[4] <= ux * look.y;
      pr1[5] <= uy * look.x;
      c1x    <= 51'(pr1[0]) - 51'(pr1[1]);
      c1y    <= 51'(pr1[2]) - 51'(pr1[3]);
      c1z    <= 51'(pr1[4]) - 51'(pr1[5]);
    end
  end

  lavm_norm #(.IN_W(51)) u_norm_right (
    .clk  (clk),
    .en   (en),
    .vec_x(c1x),
    .vec_y(c1y),
    .vec_z(c1z),
    .axis (right)
  );

  // Cross look x right
  lavm_pkg::axis_t    lk;
  logic signed [35:0] pr2 [6];
  logic signed [36:0] c2x, c2y, c2z;

  assign lk = lookb[XL-1];

  always_ff @(posedge clk) begin
    if (en) begin
      pr2[0] <= lk.y * right.z;
      pr2[1] <= lk.z * right.y;
      pr2[2] <= lk.z * right.x;
      pr2[3] <= lk.x * right.z;
      pr2[4] <= lk.x * right.y;
      pr2[5] <= lk.y * right.x;
      c2x    <= 37'(pr2[0]) - 37'(pr2[1]);
      c2y    <= 37'(pr2[2]) - 37'(pr2[3]);
      c2z    <= 37'(pr2[4]) - 37'(pr2[5]);
    end
  end

  lavm_norm #(.IN_W(37)) u_norm_up (
    .clk  (clk),
    .en   (en),
    .vec_x(c2x),
    .vec_y(c2y),
    .vec_z(c2z),
    .axis (upv)
  );

  // Translation: products, sums, then round and saturate
  logic signed [31:0] ex, ey, ez;
  lavm_pkg::axis_t    rp, vp, lp, rq, vq, lq, rr, vr, lr;
  logic signed [49:0] tp [9];
  logic signed [51:0] ts [3];
  logic signed [31:0] tr [3];

  assign ex = $signed(eyel[LC-1][95:64]);
  assign ey = $signed(eyel[LC-1][63:32]);
  assign ez = $signed(eyel[LC-1][31:0]);

  function automatic logic signed [31:0] round_sat(input logic signed [51:0] s);
    logic signed [53:0] ng;
    logic signed [37:0] tt;
    ng = -54'(s) + 54'sd32768;
    tt = ng[53:16];
    if (tt[37:31] == {7{tt[37]}}) return tt[31:0];
    return tt[37] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      tp[0] <= rightc[XL-1].x * ex;
      tp[1] <= rightc[XL-1].y * ey;
      tp[2] <= rightc[XL-1].z * ez;
      tp[3] <= upv.x * ex;
      tp[4] <= upv.y * ey;
      tp[5] <= upv.z * ez;
      tp[6] <= lookc[XL-1].x * ex;
      tp[7] <= lookc[XL-1].y * ey;
      tp[8] <= lookc[XL-1].z * ez;
      rp    <= rightc[XL-1];
      vp    <= upv;
      lp    <= lookc[XL-1];
      for (int k = 0; k < 3; k++) begin
        ts[k] <= 52'(tp[3*k]) + 52'(tp[3*k+1]) + 52'(tp[3*k+2]);
        tr[k] <= round_sat(ts[k]);
      end
      rq <= rp;
      vq <= vp;
      lq <= lp;
      rr <= rq;
      vr <= vq;
      lr <= lq;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (en && vld[DEPTH-1]) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[DEPTH-1]) begin
      m11 <= rr.x;
      m21 <= rr.y;
      m31 <= rr.z;
      m12 <= vr.x;
      m22 <= vr.y;
      m32 <= vr.z;
      m13 <= lr.x;
      m23 <= lr.y;
      m33 <= lr.z;
      tx  <= tr[0];
      ty  <= tr[1];
      tz  <= tr[2];
    end
  end

  // Checks
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted beat did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (vld[DEPTH-1] && out_valid && !out_ready) |=> (vld[DEPTH-1] && out_valid))
    else $error("result dropped during output stall");

  a_zero_right: assert property (@(posedge clk) disable iff (rst)
    (out_valid && m11 == 0 && m21 == 0 && m31 == 0) |->
    (m12 == 0 && m22 == 0 && m32 == 0 && tx == 0 && ty == 0))
    else $error("zero right axis with nonzero dependent terms");

endmodule
